### rtl/gew_pkg.sv
// Shared types, constants and divisor tables for the elevation weight pipeline.
package gew_pkg;

    localparam int WEIGHT_FRAC_BITS = 20;
    localparam int CODE_SHIFT       = 44 - WEIGHT_FRAC_BITS;

    localparam int SINE_STEPS = 3;
    localparam int LOG_STEPS  = 24;
    localparam int EXP_STEPS  = 12;

    localparam logic [32:0] Q32_ONE    = 33'h1_0000_0000;
    localparam logic [19:0] ANGLE_STEP = 20'd585635;
    localparam logic [31:0] LN2_Q32    = 32'd2977044472;
    localparam logic [13:0] PHASE_MUL  = 14'd10000;

    localparam logic [1:0] CLS_CALC = 2'd0;
    localparam logic [1:0] CLS_ZERO = 2'd1;
    localparam logic [1:0] CLS_ONE  = 2'd2;

    typedef struct packed {
        logic        vld;
        logic [7:0]  tag;
        logic        rej;
        logic [1:0]  cls;
        logic [15:0] factor;
    } ctl_t;

    // floor((2^k - 1) / d) with k = 32 + floor(log2 d)
    function automatic logic [31:0] div_mult(int d);
        logic [31:0] m;
        case (d)
            1:       m = 32'd4294967295;
            2:       m = 32'd4294967295;
            3:       m = 32'd2863311530;
            4:       m = 32'd4294967295;
            5:       m = 32'd3435973836;
            6:       m = 32'd2863311530;
            7:       m = 32'd2454267026;
            8:       m = 32'd4294967295;
            9:       m = 32'd3817748707;
            10:      m = 32'd3435973836;
            11:      m = 32'd3123612578;
            12:      m = 32'd2863311530;
            20:      m = 32'd3435973836;
            42:      m = 32'd3272356035;
            default: m = 32'd4294967295;
        endcase
        return m;
    endfunction

    function automatic int div_shift(int d);
        int k;
        case (d)
            1:                 k = 32;
            2, 3:              k = 33;
            4, 5, 6, 7:        k = 34;
            8, 9, 10, 11, 12:  k = 35;
            20:                k = 36;
            42:                k = 37;
            default:           k = 32;
        endcase
        return k;
    endfunction

    function automatic int sine_div(int i);
        int d;
        case (i)
            0:       d = 42;
            1:       d = 20;
            default: d = 6;
        endcase
        return d;
    endfunction

endpackage

### rtl/gew_neglog.sv
// Pipelined -log2 of a normalized mantissa, one squaring step per stage.
module gew_neglog
    import gew_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  ctl_t        in_ctl,
    input  logic [31:0] in_m,
    input  logic [4:0]  in_n,
    output ctl_t        out_ctl,
    output logic [29:0] out_l
);

    typedef struct packed {
        ctl_t                 ctl;
        logic [31:0]          m;
        logic [4:0]           n;
        logic [LOG_STEPS-1:0] f;
    } lg_t;

    function automatic lg_t sq_step(lg_t s);
        lg_t         r;
        logic [63:0] sq;
        logic [32:0] t;
        r  = s;
        sq = {32'd0, s.m} * {32'd0, s.m};
        t  = sq[63:31];
        r.m = t[32] ? t[32:1] : t[31:0];
        r.f = {s.f[LOG_STEPS-2:0], t[32]};
        return r;
    endfunction

    lg_t pipe [LOG_STEPS+1];

    ctl_t        ctl_reg;
    logic [29:0] l_reg;
    logic [5:0]  int_part;

    assign pipe[0] = '{ctl: in_ctl, m: in_m, n: in_n, f: '0};

    for (genvar gi = 0; gi < LOG_STEPS; gi++)
    begin : g_sq
        lg_t st_reg;
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                st_reg <= '0;
            end
            else
            begin
                st_reg <= sq_step(pipe[gi]);
            end
        end
        assign pipe[gi+1] = st_reg;
    end

    assign int_part = 6'd32 - {1'b0, pipe[LOG_STEPS].n};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
            l_reg   <= '0;
        end
        else
        begin
            ctl_reg <= pipe[LOG_STEPS].ctl;
            l_reg   <= {int_part, 24'd0} - {6'd0, pipe[LOG_STEPS].f};
        end
    end

    assign out_ctl = ctl_reg;
    assign out_l   = l_reg;

endmodule

### rtl/gnss_elevation_weight.sv
// Top level: elevation-dependent sine-power satellite weight, fully pipelined.
//
//  channel   signals                                          direction
//  request   start, busy, sat_tag, constellation,             in/out
//            elev_present, elevation
//  result    done, out_tag, rejected, code_weight,            out
//            phase_weight
//  config    psel, penable, pwrite, paddr, pwdata,            in/out
//            prdata, pready
//
// One request per cycle; busy is always low. The pipeline holds the
// 24 log2 squaring stages and the two Horner chains (three stages per
// term: multiply, reciprocal multiply, correction).
// Reset clears all valid bits and loads the register defaults.
// Results appear for one cycle on done, in request order.
module gnss_elevation_weight
    import gew_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               start,
    output logic               busy,
    input  logic [7:0]         sat_tag,
    input  logic [2:0]         constellation,
    input  logic               elev_present,
    input  logic signed [14:0] elevation,
    output logic               done,
    output logic [7:0]         out_tag,
    output logic               rejected,
    output logic [23:0]        code_weight,
    output logic [25:0]        phase_weight
);

    localparam logic [2:0] REG_EXPONENT = 3'd0;
    localparam logic [2:0] REG_GPS      = 3'd1;
    localparam logic [2:0] REG_GLONASS  = 3'd2;
    localparam logic [2:0] REG_GALILEO  = 3'd3;
    localparam logic [2:0] REG_BEIDOU   = 3'd4;

    localparam logic [2:0] SYS_GPS     = 3'd0;
    localparam logic [2:0] SYS_GLONASS = 3'd1;
    localparam logic [2:0] SYS_GALILEO = 3'd2;
    localparam logic [2:0] SYS_BEIDOU  = 3'd3;

    localparam logic [15:0]        FACTOR_ONE = 16'd4096;
    localparam logic [14:0]        EXP_RESET  = 15'd8192;
    localparam logic signed [14:0] ELEV_MAX   = 15'sd3840;

    typedef struct packed {
        ctl_t        ctl;
        logic [31:0] a;
        logic [31:0] aux;
        logic [32:0] v;
        logic [31:0] w;
    } hs_t;

    // p = (a * t) >> 32
    function automatic hs_t step_mul(hs_t s);
        hs_t         r;
        logic [64:0] prod;
        r    = s;
        prod = {33'd0, s.a} * {32'd0, s.v};
        r.v  = {1'b0, prod[63:32]};
        return r;
    endfunction

    // quotient estimate, low by at most one
    function automatic hs_t step_rcp(hs_t s, int d);
        hs_t         r;
        logic [63:0] prod;
        logic [63:0] q;
        r    = s;
        prod = {32'd0, s.v[31:0]} * {32'd0, div_mult(d)};
        q    = prod >> div_shift(d);
        r.w  = s.v[31:0];
        r.v  = {1'b0, q[31:0]};
        return r;
    endfunction

    // t = 1 - floor(p / d)
    function automatic hs_t step_fix(hs_t s, int d);
        hs_t         r;
        logic [31:0] q0;
        logic [31:0] rem;
        logic [31:0] q;
        r   = s;
        q0  = s.v[31:0];
        rem = s.w - q0 * 32'(d);
        q   = q0 + ((rem >= 32'(d)) ? 32'd1 : 32'd0);
        r.v = Q32_ONE - {1'b0, q};
        return r;
    endfunction

    logic [14:0] exponent_reg;
    logic [15:0] factor_gps_reg;
    logic [15:0] factor_glonass_reg;
    logic [15:0] factor_galileo_reg;
    logic [15:0] factor_beidou_reg;
    logic        cfg_write;
    logic [2:0]  cfg_idx;

    assign pready    = 1'b1;
    assign busy      = 1'b0;
    assign cfg_write = psel & penable & pwrite & pready;
    assign cfg_idx   = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exponent_reg       <= EXP_RESET;
            factor_gps_reg     <= FACTOR_ONE;
            factor_glonass_reg <= FACTOR_ONE;
            factor_galileo_reg <= FACTOR_ONE;
            factor_beidou_reg  <= FACTOR_ONE;
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                REG_EXPONENT: exponent_reg       <= pwdata[14:0];
                REG_GPS:      factor_gps_reg     <= pwdata[15:0];
                REG_GLONASS:  factor_glonass_reg <= pwdata[15:0];
                REG_GALILEO:  factor_galileo_reg <= pwdata[15:0];
                REG_BEIDOU:   factor_beidou_reg  <= pwdata[15:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_EXPONENT: prdata = {17'd0, exponent_reg};
            REG_GPS:      prdata = {16'd0, factor_gps_reg};
            REG_GLONASS:  prdata = {16'd0, factor_glonass_reg};
            REG_GALILEO:  prdata = {16'd0, factor_galileo_reg};
            REG_BEIDOU:   prdata = {16'd0, factor_beidou_reg};
            default:      prdata = 32'd0;
        endcase
    end

    // request capture and classification
    ctl_t        in_ctl_next;
    ctl_t        in_ctl_reg;
    logic [11:0] in_e_reg;

    always_comb
    begin
        in_ctl_next.vld = start & ~busy;
        in_ctl_next.tag = sat_tag;
        in_ctl_next.rej = ~elev_present;
        case (constellation)
            SYS_GPS:     in_ctl_next.factor = factor_gps_reg;
            SYS_GLONASS: in_ctl_next.factor = factor_glonass_reg;
            SYS_GALILEO: in_ctl_next.factor = factor_galileo_reg;
            SYS_BEIDOU:  in_ctl_next.factor = factor_beidou_reg;
            default:     in_ctl_next.factor = FACTOR_ONE;
        endcase
        if (!elev_present || elevation <= 15'sd0)
        begin
            in_ctl_next.cls = CLS_ZERO;
        end
        else if (elevation > ELEV_MAX)
        begin
            in_ctl_next.cls = CLS_ONE;
        end
        else
        begin
            in_ctl_next.cls = CLS_CALC;
        end
    end

    ctl_t        x_ctl_reg;
    logic [31:0] x_reg;
    hs_t         sq_reg;
    logic [63:0] x_sq;

    assign x_sq = {32'd0, x_reg} * {32'd0, x_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ctl_reg <= '0;
            in_e_reg   <= '0;
            x_ctl_reg  <= '0;
            x_reg      <= '0;
            sq_reg     <= '0;
        end
        else
        begin
            in_ctl_reg <= in_ctl_next;
            in_e_reg   <= elevation[11:0];
            x_ctl_reg  <= in_ctl_reg;
            x_reg      <= {20'd0, in_e_reg} * {12'd0, ANGLE_STEP};
            sq_reg     <= '{ctl: x_ctl_reg, a: x_sq[63:32], aux: x_reg,
                            v: Q32_ONE, w: 32'd0};
        end
    end

    // sine series
    hs_t sine_pipe [SINE_STEPS+1];

    assign sine_pipe[0] = sq_reg;

    for (genvar gi = 0; gi < SINE_STEPS; gi++)
    begin : g_sine
        hs_t mul_reg;
        hs_t rcp_reg;
        hs_t fix_reg;
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                mul_reg <= '0;
                rcp_reg <= '0;
                fix_reg <= '0;
            end
            else
            begin
                mul_reg <= step_mul(sine_pipe[gi]);
                rcp_reg <= step_rcp(mul_reg, sine_div(gi));
                fix_reg <= step_fix(rcp_reg, sine_div(gi));
            end
        end
        assign sine_pipe[gi+1] = fix_reg;
    end

    ctl_t        ym_ctl_reg;
    logic [32:0] ym_reg;
    logic [64:0] ym_prod;

    assign ym_prod = {33'd0, sine_pipe[SINE_STEPS].aux} * {32'd0, sine_pipe[SINE_STEPS].v};

    // clamp and normalize for log2
    ctl_t        nrm_ctl_next;
    logic [33:0] y_full;
    logic [31:0] y_low;
    logic [4:0]  lead_next;
    logic [31:0] m_next;
    ctl_t        nrm_ctl_reg;
    logic [4:0]  lead_reg;
    logic [31:0] m_reg;

    always_comb
    begin
        y_full       = {ym_reg, 1'b0};
        y_low        = y_full[31:0];
        nrm_ctl_next = ym_ctl_reg;
        if (ym_ctl_reg.cls == CLS_CALC)
        begin
            if (y_full == 34'd0)
            begin
                nrm_ctl_next.cls = CLS_ZERO;
            end
            else if (y_full[33:32] != 2'b00)
            begin
                nrm_ctl_next.cls = CLS_ONE;
            end
        end
        lead_next = 5'd0;
        for (int i = 0; i < 32; i++)
        begin
            if (y_low[i])
            begin
                lead_next = 5'(i);
            end
        end
        m_next = y_low << (5'd31 - lead_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ym_ctl_reg  <= '0;
            ym_reg      <= '0;
            nrm_ctl_reg <= '0;
            lead_reg    <= '0;
            m_reg       <= '0;
        end
        else
        begin
            ym_ctl_reg  <= sine_pipe[SINE_STEPS].ctl;
            ym_reg      <= ym_prod[64:32];
            nrm_ctl_reg <= nrm_ctl_next;
            lead_reg    <= lead_next;
            m_reg       <= m_next;
        end
    end

    ctl_t        lg_ctl;
    logic [29:0] lg_l;

    gew_neglog u_neglog (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ctl  (nrm_ctl_reg),
        .in_m    (m_reg),
        .in_n    (lead_reg),
        .out_ctl (lg_ctl),
        .out_l   (lg_l)
    );

    // power and exp2 argument
    ctl_t        e_ctl_reg;
    logic [32:0] e_reg;
    logic [44:0] e_prod;
    logic [55:0] u_prod;
    ctl_t        u_ctl_next;
    hs_t         u_reg;

    assign e_prod = {15'd0, lg_l} * {30'd0, exponent_reg};
    assign u_prod = {32'd0, e_reg[23:0]} * {24'd0, LN2_Q32};

    always_comb
    begin
        u_ctl_next = e_ctl_reg;
        if (e_ctl_reg.cls == CLS_CALC && e_reg[32:24] >= 9'd33)
        begin
            u_ctl_next.cls = CLS_ZERO;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_ctl_reg <= '0;
            e_reg     <= '0;
            u_reg     <= '0;
        end
        else
        begin
            e_ctl_reg <= lg_ctl;
            e_reg     <= e_prod[44:12];
            u_reg     <= '{ctl: u_ctl_next, a: u_prod[55:24],
                           aux: {26'd0, e_reg[29:24]}, v: Q32_ONE, w: 32'd0};
        end
    end

    // exp series, divisors from EXP_STEPS down to one
    hs_t exp_pipe [EXP_STEPS+1];

    assign exp_pipe[0] = u_reg;

    for (genvar gi = 0; gi < EXP_STEPS; gi++)
    begin : g_exp
        hs_t mul_reg;
        hs_t rcp_reg;
        hs_t fix_reg;
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                mul_reg <= '0;
                rcp_reg <= '0;
                fix_reg <= '0;
            end
            else
            begin
                mul_reg <= step_mul(exp_pipe[gi]);
                rcp_reg <= step_rcp(mul_reg, EXP_STEPS - gi);
                fix_reg <= step_fix(rcp_reg, EXP_STEPS - gi);
            end
        end
        assign exp_pipe[gi+1] = fix_reg;
    end

    // base weight, scaling, rounding
    hs_t         ex_out;
    logic [32:0] base_next;
    ctl_t        base_ctl_reg;
    logic [32:0] base_reg;
    ctl_t        p_ctl_reg;
    logic [48:0] p_reg;
    ctl_t        q_ctl_reg;
    logic [62:0] pp_reg;
    logic [23:0] code_next;
    logic [23:0] code_reg;
    logic [49:0] code_sum;
    logic [49:0] code_shr;
    logic [63:0] phase_sum;
    logic [27:0] phase_shr;
    logic [25:0] phase_next;

    assign ex_out = exp_pipe[EXP_STEPS];

    always_comb
    begin
        case (ex_out.ctl.cls)
            CLS_ZERO: base_next = 33'd0;
            CLS_ONE:  base_next = Q32_ONE;
            default:  base_next = ex_out.v >> ex_out.aux[5:0];
        endcase
        code_sum  = {1'b0, p_reg} + (50'd1 << (CODE_SHIFT - 1));
        code_shr  = code_sum >> CODE_SHIFT;
        code_next = (code_shr[49:24] != 26'd0) ? 24'hFF_FFFF : code_shr[23:0];
        phase_sum  = {1'b0, pp_reg} + (64'd1 << 35);
        phase_shr  = phase_sum[63:36];
        phase_next = (phase_shr[27:26] != 2'b00) ? 26'h3FF_FFFF : phase_shr[25:0];
    end

    logic        done_reg;
    logic [7:0]  out_tag_reg;
    logic        rejected_reg;
    logic [23:0] code_weight_reg;
    logic [25:0] phase_weight_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_ctl_reg     <= '0;
            base_reg         <= '0;
            p_ctl_reg        <= '0;
            p_reg            <= '0;
            q_ctl_reg        <= '0;
            pp_reg           <= '0;
            code_reg         <= '0;
            done_reg         <= 1'b0;
            out_tag_reg      <= '0;
            rejected_reg     <= 1'b0;
            code_weight_reg  <= '0;
            phase_weight_reg <= '0;
        end
        else
        begin
            base_ctl_reg     <= ex_out.ctl;
            base_reg         <= base_next;
            p_ctl_reg        <= base_ctl_reg;
            p_reg            <= {16'd0, base_reg} * {33'd0, base_ctl_reg.factor};
            q_ctl_reg        <= p_ctl_reg;
            pp_reg           <= {14'd0, p_reg} * {49'd0, PHASE_MUL};
            code_reg         <= code_next;
            done_reg         <= q_ctl_reg.vld;
            out_tag_reg      <= q_ctl_reg.tag;
            rejected_reg     <= q_ctl_reg.rej;
            code_weight_reg  <= code_reg;
            phase_weight_reg <= phase_next;
        end
    end

    assign done         = done_reg;
    assign out_tag      = out_tag_reg;
    assign rejected     = rejected_reg;
    assign code_weight  = code_weight_reg;
    assign phase_weight = phase_weight_reg;

endmodule

### tb/tb_top.sv
// Testbench for gnss_elevation_weight: directed and random requests checked against a fixed-point weight model.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import gew_pkg::*;

    localparam logic [4:0] REG_EXPONENT = 5'd0;
    localparam logic [4:0] REG_GPS      = 5'd4;
    localparam logic [4:0] REG_GLONASS  = 5'd8;
    localparam logic [4:0] REG_GALILEO  = 5'd12;
    localparam logic [4:0] REG_BEIDOU   = 5'd16;
    localparam logic [2:0] SYS_GPS      = 3'd0;
    localparam logic [2:0] SYS_GLONASS  = 3'd1;
    localparam logic [2:0] SYS_GALILEO  = 3'd2;
    localparam logic [2:0] SYS_BEIDOU   = 3'd3;
    localparam int PIPE_LATENCY = 82;

    typedef struct packed {
        logic [7:0]         tag;
        logic [2:0]         sys;
        logic               present;
        logic signed [14:0] elev;
    } obs_t;

    typedef struct packed {
        logic [7:0]  tag;
        logic        rej;
        logic [23:0] code;
        logic [25:0] phase;
    } weight_t;

    logic clk, rst_n;
    logic psel, penable, pwrite, pready;
    logic [4:0] paddr;
    logic [31:0] pwdata, prdata;
    logic start, busy, elev_present, done, rejected;
    logic [7:0] sat_tag, out_tag;
    logic [2:0] constellation;
    logic signed [14:0] elevation;
    logic [23:0] code_weight;
    logic [25:0] phase_weight;

    gnss_elevation_weight uut (.*);

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    logic [14:0] m_exponent;
    logic [15:0] m_factor [4];
    obs_t    pending_obs [$];
    weight_t expected_weights [$];
    int      errors = 0;
    int      idle_pct = 37;

    function automatic logic [63:0] twice_sine(logic [63:0] e);
        logic [63:0] x, x2, t, y;
        x  = e * 64'd585635;
        x2 = (x * x) >> 32;
        t  = 64'h1_0000_0000 - x2 / 42;
        t  = 64'h1_0000_0000 - ((x2 * t) >> 32) / 20;
        t  = 64'h1_0000_0000 - ((x2 * t) >> 32) / 6;
        y  = ((x * t) >> 32) << 1;
        return (y > 64'h1_0000_0000) ? 64'h1_0000_0000 : y;
    endfunction

    function automatic logic [63:0] neg_log2(logic [63:0] y);
        int n;
        logic [63:0] m, f;
        n = 31;
        while (n > 0 && y[n] == 1'b0)
            n--;
        m = y << (31 - n);
        f = 0;
        for (int i = 0; i < 24; i++)
        begin
            m = (m * m) >> 31;
            f = f << 1;
            if (m >= 64'h1_0000_0000)
            begin
                f[0] = 1'b1;
                m = m >> 1;
            end
        end
        return (64'(32 - n) << 24) - f;
    endfunction

    function automatic logic [63:0] exp2_neg(logic [63:0] e);
        logic [63:0] k, u, t;
        k = e >> 24;
        if (k >= 33)
            return 0;
        u = ((e & 64'hFF_FFFF) * 64'd2977044472) >> 24;
        t = 64'h1_0000_0000;
        for (int d = 12; d >= 1; d--)
            t = 64'h1_0000_0000 - ((u * t) >> 32) / d;
        return t >> k;
    endfunction

    function automatic weight_t predict_weight(obs_t o);
        weight_t r;
        logic [63:0] base, y, fac, p;
        logic [127:0] code, phase;
        r = '0;
        r.tag = o.tag;
        if (!o.present)
        begin
            r.rej = 1'b1;
            return r;
        end
        if (o.elev <= 0)
            base = 0;
        else if (o.elev > 3840)
            base = 64'h1_0000_0000;
        else
        begin
            y = twice_sine(64'(o.elev));
            if (y == 0)
                base = 0;
            else if (y >= 64'h1_0000_0000)
                base = 64'h1_0000_0000;
            else
                base = exp2_neg((neg_log2(y) * m_exponent) >> 12);
        end
        fac = (o.sys <= SYS_BEIDOU) ? 64'(m_factor[o.sys[1:0]]) : 64'd4096;
        p = base * fac;
        code  = (128'(p) + (128'd1 << 23)) >> 24;
        phase = (128'(p) * 10000 + (128'd1 << 35)) >> 36;
        r.code  = (code > 128'hFF_FFFF) ? 24'hFF_FFFF : code[23:0];
        r.phase = (phase > 128'h3FF_FFFF) ? 26'h3FF_FFFF : phase[25:0];
        return r;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            sat_tag <= '0;
            constellation <= '0;
            elev_present <= 1'b0;
            elevation <= '0;
        end
        else
        begin
            obs_t o;
            if (start && !busy)
                expected_weights.push_back(predict_weight(pending_obs.pop_front()));
            if (pending_obs.size() > 0 && $urandom_range(99) >= idle_pct)
            begin
                o = pending_obs[0];
                start <= 1'b1;
                sat_tag <= o.tag;
                constellation <= o.sys;
                elev_present <= o.present;
                elevation <= o.elev;
            end
            else
                start <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            weight_t exp_w, got;
            got = '{out_tag, rejected, code_weight, phase_weight};
            if (expected_weights.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                errors++;
            end
            else
            begin
                exp_w = expected_weights.pop_front();
                if (got.tag !== exp_w.tag)
                begin
                    $display("%0t: out_tag expected %0d actual %0d", $time, exp_w.tag, got.tag);
                    errors++;
                end
                if (got.rej !== exp_w.rej)
                begin
                    $display("%0t: rejected expected %0d actual %0d", $time, exp_w.rej, got.rej);
                    errors++;
                end
                if (got.code !== exp_w.code)
                begin
                    $display("%0t: code_weight expected %0d actual %0d",
                             $time, exp_w.code, got.code);
                    errors++;
                end
                if (got.phase !== exp_w.phase)
                begin
                    $display("%0t: phase_weight expected %0d actual %0d",
                             $time, exp_w.phase, got.phase);
                    errors++;
                end
            end
        end
    end

    task automatic write_reg(logic [4:0] addr, logic [31:0] data);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (addr)
            REG_EXPONENT: m_exponent = data[14:0];
            REG_GPS:      m_factor[0] = data[15:0];
            REG_GLONASS:  m_factor[1] = data[15:0];
            REG_GALILEO:  m_factor[2] = data[15:0];
            REG_BEIDOU:   m_factor[3] = data[15:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        while (pending_obs.size() > 0 || start || expected_weights.size() > 0)
            @(posedge clk);
        repeat (PIPE_LATENCY + 4) @(posedge clk);
    endtask

    task automatic set_regs(logic [14:0] ex, logic [15:0] f0, logic [15:0] f1,
                            logic [15:0] f2, logic [15:0] f3);
        write_reg(REG_EXPONENT, 32'(ex));
        write_reg(REG_GPS, 32'(f0));
        write_reg(REG_GLONASS, 32'(f1));
        write_reg(REG_GALILEO, 32'(f2));
        write_reg(REG_BEIDOU, 32'(f3));
    endtask

    function automatic obs_t rand_obs();
        obs_t o;
        int sel;
        o.tag = 8'($urandom);
        o.sys = 3'($urandom);
        o.present = ($urandom_range(9) != 0);
        sel = $urandom_range(9);
        if (sel < 6)
            o.elev = 15'($urandom_range(3840, 1));
        else if (sel < 8)
            o.elev = 15'(signed'($urandom_range(23040)) - 11520);
        else
            o.elev = 15'($urandom);
        return o;
    endfunction

    task automatic add_obs(logic [7:0] tag, logic [2:0] sys, logic pres, int elev);
        pending_obs.push_back('{tag, sys, pres, 15'(elev)});
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        m_exponent = 15'd8192;
        m_factor = '{16'd4096, 16'd4096, 16'd4096, 16'd4096};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_obs(8'h00, SYS_GPS, 1'b1, 3840);
        add_obs(8'hFF, SYS_GLONASS, 1'b1, 3841);
        add_obs(8'h55, SYS_GALILEO, 1'b1, 1);
        add_obs(8'hAA, SYS_BEIDOU, 1'b1, 0);
        add_obs(8'h01, 3'd4, 1'b1, -1);
        add_obs(8'h02, 3'd7, 1'b1, -11520);
        add_obs(8'h03, SYS_GPS, 1'b1, 11520);
        add_obs(8'h04, SYS_GPS, 1'b0, 1000);
        add_obs(8'h05, 3'd5, 1'b1, 16383);
        add_obs(8'h06, 3'd6, 1'b1, -16384);
        add_obs(8'h07, SYS_GLONASS, 1'b1, 1920);
        add_obs(8'h08, SYS_GALILEO, 1'b1, 128);
        drain();

        set_regs(15'd0, 16'hFFFF, 16'd0, 16'd1, 16'd8192);
        add_obs(8'h10, SYS_GPS, 1'b1, 500);
        add_obs(8'h11, SYS_GLONASS, 1'b1, 4000);
        add_obs(8'h12, SYS_GALILEO, 1'b1, 2000);
        add_obs(8'h13, SYS_BEIDOU, 1'b1, 10);
        add_obs(8'h14, SYS_GPS, 1'b1, 11520);
        drain();

        set_regs(15'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        add_obs(8'h20, SYS_GPS, 1'b1, 1);
        add_obs(8'h21, SYS_GLONASS, 1'b1, 3840);
        add_obs(8'h22, SYS_BEIDOU, 1'b1, 3000);
        for (int i = 0; i < 150; i++)
            pending_obs.push_back(rand_obs());
        drain();

        for (int phase = 0; phase < 6; phase++)
        begin
            idle_pct = (phase < 2) ? 37 : (phase < 4) ? 77 : 0;
            set_regs(15'($urandom), 16'($urandom), 16'($urandom),
                     16'($urandom_range(8192)), 16'($urandom_range(4096, 2048)));
            for (int i = 0; i < 260; i++)
                pending_obs.push_back(rand_obs());
            drain();
        end

        if (errors == 0)
            $display("gnss_elevation_weight verification clean");
        else
            $display("gnss_elevation_weight verification failed");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("gnss_elevation_weight verification failed");
        $finish;
    end
endmodule
